FILE: rtl/cpu_scheduling_simulator_assert.svh
// ---------------------------------------------------------------------------
// CPU scheduling simulator assertion macros
// Concurrent assertion wrappers, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef CPU_SCHEDULING_SIMULATOR_ASSERT_SVH
`define CPU_SCHEDULING_SIMULATOR_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define CSS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define CSS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CSS_ASSERT_IMP(lbl, ante, cons)
`define CSS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/css_pkg.sv
// ---------------------------------------------------------------------------
// CPU scheduling simulator package
// Sizes, mode codes and the command and status bundles.
// ---------------------------------------------------------------------------
package css_pkg;
    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = $clog2(MAX_PROCS);
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int TICK_W    = 21;
    localparam int SUM_W     = 25;

    localparam logic [2:0] MODE_FCFS = 3'd0;
    localparam logic [2:0] MODE_SJF  = 3'd1;
    localparam logic [2:0] MODE_RR   = 3'd2;
    localparam logic [2:0] MODE_SRTF = 3'd3;
    localparam logic [2:0] MODE_PRIO = 3'd4;
    localparam logic [2:0] MODE_PRIP = 3'd5;

    localparam logic [1:0] REG_SCHED_MODE = 2'd0;
    localparam logic [1:0] REG_QUANTUM    = 2'd1;

    typedef struct packed {
        logic load;       // insert the accepted record
        logic init;       // start a run
        logic scan_clr;   // restart the table scan
        logic scan_en;    // examine one entry
        logic idle_adv;   // move the tick to the next ready time
        logic dispatch;   // run the chosen entry for one slice
        logic requeue;    // cut-off entry becomes ready again
        logic finish;     // chosen entry completed
        logic emit;       // load the result register
        logic count_clr;  // empty the table after the run
    } css_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic have_best;
        logic rem_left;
        logic run_done;
        logic out_free;
    } css_status_t;
endpackage

FILE: rtl/css_ctrl.sv
// ---------------------------------------------------------------------------
// CPU scheduling simulator controller
// Sequences loading, table scans, dispatch and result hand-off.
// ---------------------------------------------------------------------------
module css_ctrl
    import css_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_last,
    output logic        in_ready,
    input  css_status_t status,
    output css_cmd_t    cmd
);
`include "cpu_scheduling_simulator_assert.svh"

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_DECIDE,
        ST_CHECK,
        ST_EMIT
    } state_t;

    state_t st_reg, st_next;

    always_comb
    begin
        st_next  = st_reg;
        cmd      = '0;
        in_ready = 1'b0;
        unique case (st_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                        st_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.init     = 1'b1;
                cmd.scan_clr = 1'b1;
                st_next      = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (status.scan_last)
                    st_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (status.have_best)
                begin
                    cmd.dispatch = 1'b1;
                    st_next      = ST_CHECK;
                end
                else
                begin
                    cmd.idle_adv = 1'b1;
                    cmd.scan_clr = 1'b1;
                    st_next      = ST_SCAN;
                end
            end
            ST_CHECK:
            begin
                if (status.rem_left)
                begin
                    cmd.requeue  = 1'b1;
                    cmd.scan_clr = 1'b1;
                    st_next      = ST_SCAN;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    st_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.run_done)
                    begin
                        cmd.count_clr = 1'b1;
                        st_next       = ST_IDLE;
                    end
                    else
                    begin
                        cmd.scan_clr = 1'b1;
                        st_next      = ST_SCAN;
                    end
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= ST_IDLE;
        else
            st_reg <= st_next;
    end

    `CSS_ASSERT_NXT(a_emit_exit, st_reg == ST_EMIT && status.out_free, st_reg == ST_IDLE || st_reg == ST_SCAN)
    `CSS_ASSERT_NXT(a_scan_hold, st_reg == ST_SCAN && !status.scan_last, st_reg == ST_SCAN)
    `CSS_ASSERT_NXT(a_check_exit, st_reg == ST_CHECK, st_reg == ST_SCAN || st_reg == ST_EMIT)
endmodule

FILE: rtl/css_datapath.sv
// ---------------------------------------------------------------------------
// CPU scheduling simulator datapath
// Process table, scan comparator, tick and sums, result register.
// ---------------------------------------------------------------------------
module css_datapath
    import css_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  css_cmd_t      cmd,
    output css_status_t   status,
    input  logic          cfg_valid,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    input  logic [15:0]   in_arrival,
    input  logic [15:0]   in_burst,
    input  logic [7:0]    in_priority,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [3:0]    out_index,
    output logic [20:0]   out_completion,
    output logic [20:0]   out_turnaround,
    output logic [20:0]   out_wait,
    output logic [24:0]   out_total_turn,
    output logic [24:0]   out_total_wait,
    output logic          out_last
);
    logic [15:0]       arr_reg  [MAX_PROCS];
    logic [15:0]       bur_reg  [MAX_PROCS];
    logic [15:0]       rem_reg  [MAX_PROCS];
    logic [7:0]        pri_reg  [MAX_PROCS];
    logic [TICK_W-1:0] rt_reg   [MAX_PROCS];
    logic [3:0]        lo_reg   [MAX_PROCS];
    logic [MAX_PROCS-1:0] done_reg;
    logic [CNT_W-1:0]  count_reg, fin_reg;
    logic [TICK_W-1:0] tick_reg;
    logic [SUM_W-1:0]  sum_t_reg, sum_w_reg;
    logic [2:0]        mode_reg;
    logic [15:0]       quant_reg;

    logic [IDX_W-1:0]  idx_reg, best_idx_reg;
    logic              have_best_reg;
    logic [15:0]       best_rem_reg, best_arr_reg, best_bur_reg;
    logic [7:0]        best_pri_reg;
    logic [TICK_W-1:0] best_rt_reg, next_rt_reg;
    logic [15:0]       disp_rem_reg;
    logic [TICK_W-1:0] turn_reg, wait_reg;

    // Slice length.
    logic        sliced;
    logic [15:0] quant_eff, slice;

    assign sliced    = (mode_reg == MODE_RR) || (mode_reg == MODE_SRTF) ||
                       (mode_reg == MODE_PRIP);
    assign quant_eff = (quant_reg == 16'd0) ? 16'd1 : quant_reg;
    assign slice     = (sliced && best_rem_reg > quant_eff) ? quant_eff : best_rem_reg;

    // Insertion: an entry after the new record's place shifts up by one.
    logic [MAX_PROCS-1:0] later;
    logic                 can_load;

    always_comb
    begin
        for (int j = 0; j < MAX_PROCS; j++)
            later[j] = (CNT_W'(j) < count_reg) && (arr_reg[j] > in_arrival);
    end

    assign can_load = cmd.load && (count_reg < CNT_W'(MAX_PROCS));

    genvar g;
    generate
        for (g = 0; g < MAX_PROCS; g++)
        begin : g_entry
            logic keep, take_new;
            assign keep     = !later[g] && (CNT_W'(g) < count_reg);
            if (g == 0)
            begin : g_first
                assign take_new = 1'b1;
            end
            else
            begin : g_rest
                assign take_new = !later[g-1];
            end

            always_ff @(posedge clk)
            begin
                if (can_load && !keep && (CNT_W'(g) <= count_reg))
                begin
                    if (take_new)
                    begin
                        arr_reg[g] <= in_arrival;
                        bur_reg[g] <= in_burst;
                        rem_reg[g] <= in_burst;
                        pri_reg[g] <= in_priority;
                        rt_reg[g]  <= TICK_W'(in_arrival);
                        lo_reg[g]  <= count_reg[3:0];
                    end
                    else if (g > 0)
                    begin
                        arr_reg[g] <= arr_reg[(g > 0) ? g - 1 : 0];
                        bur_reg[g] <= bur_reg[(g > 0) ? g - 1 : 0];
                        rem_reg[g] <= rem_reg[(g > 0) ? g - 1 : 0];
                        pri_reg[g] <= pri_reg[(g > 0) ? g - 1 : 0];
                        rt_reg[g]  <= rt_reg[(g > 0) ? g - 1 : 0];
                        lo_reg[g]  <= lo_reg[(g > 0) ? g - 1 : 0];
                    end
                end
                else if (cmd.dispatch && best_idx_reg == IDX_W'(g))
                begin
                    rem_reg[g] <= best_rem_reg - slice;
                end
                else if (cmd.requeue && best_idx_reg == IDX_W'(g))
                begin
                    rt_reg[g] <= tick_reg;
                end
            end
        end
    endgenerate

    // Scan candidate.
    logic [15:0]       c_rem, c_arr, c_bur;
    logic [7:0]        c_pri;
    logic [TICK_W-1:0] c_rt;
    logic              c_beats, c_ready, c_live;

    assign c_rem   = rem_reg[idx_reg];
    assign c_arr   = arr_reg[idx_reg];
    assign c_bur   = bur_reg[idx_reg];
    assign c_pri   = pri_reg[idx_reg];
    assign c_rt    = rt_reg[idx_reg];
    assign c_live  = !done_reg[idx_reg];
    assign c_ready = c_rt <= tick_reg;

    always_comb
    begin
        unique case (mode_reg)
            MODE_SJF, MODE_SRTF: c_beats = c_rem < best_rem_reg;
            MODE_PRIO, MODE_PRIP: c_beats = c_pri > best_pri_reg;
            MODE_RR:
                c_beats = (c_rt < best_rt_reg) ||
                          ((c_rt == best_rt_reg) && (c_arr < best_arr_reg));
            default: c_beats = 1'b0;
        endcase
    end

    assign status.scan_last = ({1'b0, idx_reg} == CNT_W'(count_reg - CNT_W'(1)));
    assign status.have_best = have_best_reg;
    assign status.rem_left  = disp_rem_reg != 16'd0;
    assign status.run_done  = fin_reg == count_reg;
    assign status.out_free  = !out_valid || out_ready;

    logic [SUM_W-1:0] sum_t_next, sum_w_next;
    assign sum_t_next = sum_t_reg + SUM_W'(turn_reg);
    assign sum_w_next = sum_w_reg + SUM_W'(wait_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_FCFS;
            quant_reg     <= 16'd4;
            count_reg     <= '0;
            fin_reg       <= '0;
            done_reg      <= '0;
            tick_reg      <= '0;
            sum_t_reg     <= '0;
            sum_w_reg     <= '0;
            idx_reg       <= '0;
            have_best_reg <= 1'b0;
            out_valid     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == REG_SCHED_MODE)
                mode_reg <= cfg_data[2:0];
            else if (cfg_valid && cfg_index == REG_QUANTUM)
                quant_reg <= cfg_data;

            if (can_load)
                count_reg <= count_reg + CNT_W'(1);
            else if (cmd.count_clr)
                count_reg <= '0;

            if (cmd.init)
            begin
                fin_reg   <= '0;
                done_reg  <= '0;
                tick_reg  <= '0;
                sum_t_reg <= '0;
                sum_w_reg <= '0;
            end

            if (cmd.scan_clr)
            begin
                idx_reg       <= '0;
                have_best_reg <= 1'b0;
            end
            else if (cmd.scan_en)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
                if (c_live && c_ready && (!have_best_reg || c_beats))
                    have_best_reg <= 1'b1;
            end

            if (cmd.idle_adv)
                tick_reg <= next_rt_reg;
            else if (cmd.dispatch)
                tick_reg <= tick_reg + TICK_W'(slice);

            if (cmd.finish)
            begin
                done_reg[best_idx_reg] <= 1'b1;
                fin_reg                <= fin_reg + CNT_W'(1);
            end

            if (cmd.emit)
            begin
                sum_t_reg <= sum_t_next;
                sum_w_reg <= sum_w_next;
                out_valid <= 1'b1;
            end
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_clr)
            next_rt_reg <= '1;
        else if (cmd.scan_en && c_live)
        begin
            if (c_ready)
            begin
                if (!have_best_reg || c_beats)
                begin
                    best_idx_reg <= idx_reg;
                    best_rem_reg <= c_rem;
                    best_arr_reg <= c_arr;
                    best_bur_reg <= c_bur;
                    best_pri_reg <= c_pri;
                    best_rt_reg  <= c_rt;
                end
            end
            else if (c_rt < next_rt_reg)
                next_rt_reg <= c_rt;
        end

        if (cmd.dispatch)
            disp_rem_reg <= best_rem_reg - slice;

        if (cmd.finish)
        begin
            turn_reg <= tick_reg - TICK_W'(best_arr_reg);
            wait_reg <= tick_reg - TICK_W'(best_arr_reg) - TICK_W'(best_bur_reg);
        end

        if (cmd.emit)
        begin
            out_index      <= lo_reg[best_idx_reg];
            out_completion <= tick_reg;
            out_turnaround <= turn_reg;
            out_wait       <= wait_reg;
            out_total_turn <= sum_t_next;
            out_total_wait <= sum_w_next;
            out_last       <= status.run_done;
        end
    end
endmodule

FILE: rtl/cpu_scheduling_simulator.sv
// ---------------------------------------------------------------------------
// CPU scheduling simulator
// Loads process records, then schedules them and streams one result each.
// ---------------------------------------------------------------------------
// Records enter on s_axis; each accepted item is placed into the arrival-
// sorted table while it holds fewer than 16 entries; an item that arrives
// at a full table is dropped. The item with tlast set starts the run.
// During a run s_axis_tready is low. Each dispatch decision scans the
// table one entry per cycle; a slice that finishes a process then passes
// through the check and emit states before its result is loaded into the
// output register, and a slice that is cut off returns to a new scan.
// Results leave on m_axis in completion order; tlast marks the final one.
// When the receiver stalls, the run holds at the next result until the
// output register is taken. The cfg channel is always ready: index 0 sets
// the mode, index 1 the quantum. Reset empties the table, sets FCFS and a
// quantum of four.
// ---------------------------------------------------------------------------
module cpu_scheduling_simulator
    import css_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // arrival_time[15:0], burst_time[31:16], priority_req[39:32]
    input  logic [39:0]  s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // process_index[3:0], completion_time[24:4], turnaround_time[45:25],
    // wait_time[66:46], total_turnaround[91:67], total_wait[116:92], zero pad
    output logic [119:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    css_cmd_t    cmd;
    css_status_t status;

    logic [3:0]  o_idx;
    logic [20:0] o_comp, o_turn, o_wait;
    logic [24:0] o_tt, o_tw;

    assign cfg_ready = 1'b1;

    css_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    css_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_arrival     (s_axis_tdata[15:0]),
        .in_burst       (s_axis_tdata[31:16]),
        .in_priority    (s_axis_tdata[39:32]),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_index      (o_idx),
        .out_completion (o_comp),
        .out_turnaround (o_turn),
        .out_wait       (o_wait),
        .out_total_turn (o_tt),
        .out_total_wait (o_tw),
        .out_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, o_tw, o_tt, o_wait, o_turn, o_comp, o_idx};
endmodule
